/* rtl/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg: shared constants and function of the contrast ratio core
//
// Holds the sRGB linearization function that builds the constant channel table
// at elaboration time.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ChanVals = 256;

  // Linearized sRGB channel, rounded to nearest, scaled by 2^frac.
  // Linear segment for codes up to 10, power segment above.
  function automatic longint ccr_lin_entry(input int v, input int frac);
    real x;
    real y;
    longint r;
    x = 0.0;
    y = 0.0;
    r = 0;
    if ((longint'(v) * 100000) <= 1001640) begin
      r = ((longint'(v) << (frac + 1)) * 10 + 32946) / 65892;
    end else begin
      x = (40.0 * v + 561.0) / 10761.0;
      y = $pow(x, 2.4) * (2.0 ** frac);
      r = longint'($rtoi(y + 0.5));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ccr_div.sv */
// ----------------------------------------------------------------------------
// ccr_div: pipelined restoring divider
//
// One quotient bit per register stage, most significant first. A side word
// travels with each division. Stages collapse bubbles under back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_div #(
  parameter int unsigned NumW  = 26,
  parameter int unsigned DenW  = 18,
  parameter int unsigned QuoW  = 13,
  parameter int unsigned SideW = 34
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [DenW-1:0]  den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [QuoW-1:0]       quo_o,
  output logic [SideW-1:0]      side_o
);

  localparam int unsigned ShW = DenW + QuoW;
  localparam int unsigned CmpW = (NumW > ShW) ? NumW : ShW;

  logic [QuoW-1:0]  vld_q;
  logic [QuoW-1:0]  en;
  logic [CmpW-1:0]  rem_q  [QuoW];
  logic [DenW-1:0]  den_q  [QuoW];
  logic [QuoW-1:0]  quo_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  // stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    en[QuoW-1] = !vld_q[QuoW-1] || out_ready_i;
    for (int k = QuoW - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - s;
    logic [CmpW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [SideW-1:0] side_in;
    logic            vld_in;
    logic [CmpW-1:0] dsh;
    logic            take;

    if (s == 0) begin : g_first
      assign rem_in  = CmpW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = in_valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // trial subtract of the shifted divisor
    assign dsh  = CmpW'(den_in) << Bit;
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en[s]) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && vld_in) begin
        rem_q[s]  <= take ? (rem_in - dsh) : rem_in;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_in | (QuoW'(take) << Bit);
        side_q[s] <= side_in;
      end
    end
  end

  assign out_valid_o = vld_q[QuoW-1];
  assign quo_o       = quo_q[QuoW-1];
  assign side_o      = side_q[QuoW-1];

  // remainder always ends below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rem_q[QuoW-1] < CmpW'(den_q[QuoW-1])))
    else $error("ccr_div: final remainder not below divisor");

  // a held word does not lose its quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(quo_o)))
    else $error("ccr_div: stalled quotient changed");

  // divisor never zero while a word is in the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (den_q[QuoW-1] != '0))
    else $error("ccr_div: zero divisor");

endmodule

`default_nettype wire

/* rtl/color_contrast_ratio_core.sv */
// ----------------------------------------------------------------------------
// color_contrast_ratio_core: WCAG contrast ratio of two sRGB colors
//
// Input channel: in_valid_i/in_ready_o with six 8-bit sRGB channels, first
// and second color. Output channel: out_valid_o/out_ready_i with the ratio
// (RATIO_FRAC_BITS fraction bits, truncated) and both relative luminances
// (LUM_FRAC_BITS fraction bits).
// One word is accepted per cycle while in_ready_o is high. The registered steps are
// table lookup, weight multiply, luminance sum, min/max and offset, then the
// pipelined divider, which forms the quotient bits most significant first.
// Each stage holds its word until the next stage can take it, so when the
// receiver stalls the pipeline fills up, bubbles are squeezed out, and
// in_ready_o drops only once every stage is full. Nothing is lost or repeated.
// Reset clears all valid bits; there is no state carried between words.
// ----------------------------------------------------------------------------
`default_nettype none

module color_contrast_ratio_core #(
  parameter int unsigned LUM_FRAC_BITS   = 16,
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [ccr_pkg::ChanW-1:0]  first_red_i,
  input  wire logic [ccr_pkg::ChanW-1:0]  first_green_i,
  input  wire logic [ccr_pkg::ChanW-1:0]  first_blue_i,
  input  wire logic [ccr_pkg::ChanW-1:0]  second_red_i,
  input  wire logic [ccr_pkg::ChanW-1:0]  second_green_i,
  input  wire logic [ccr_pkg::ChanW-1:0]  second_blue_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [RATIO_FRAC_BITS+4:0]      ratio_q8_o,
  output logic [LUM_FRAC_BITS:0]          first_luminance_o,
  output logic [LUM_FRAC_BITS:0]          second_luminance_o
);

  import ccr_pkg::*;

  localparam int unsigned F    = LUM_FRAC_BITS;
  localparam int unsigned R    = RATIO_FRAC_BITS;
  localparam int unsigned LinW = F + 1;
  localparam int unsigned LumW = F + 1;
  localparam int unsigned PrW  = LinW + F;
  localparam int unsigned SumW = PrW + 2;
  localparam int unsigned DenW = LumW + 1;
  localparam int unsigned NumW = DenW + R;
  localparam int unsigned QuoW = R + 5;
  localparam int unsigned SideW = 2 * LumW;

  localparam longint WRed   = ((longint'(2126) << F) + 5000) / 10000;
  localparam longint WGreen = ((longint'(7152) << F) + 5000) / 10000;
  localparam longint WBlue  = ((longint'(722) << F) + 5000) / 10000;
  localparam longint LumOff = ((longint'(5) << F) + 50) / 100;
  localparam longint Half   = longint'(1) << (F - 1);

  localparam logic [F-1:0]    W_R   = F'(WRed);
  localparam logic [F-1:0]    W_G   = F'(WGreen);
  localparam logic [F-1:0]    W_B   = F'(WBlue);
  localparam logic [DenW-1:0] OFF   = DenW'(LumOff);
  localparam logic [SumW-1:0] HALF  = SumW'(Half);
  localparam logic [QuoW-1:0] ONE_R = QuoW'(1) << R;

  // constant linearization table, built at elaboration
  logic [LinW-1:0] lin_rom [ChanVals];
  for (genvar g = 0; g < ChanVals; g++) begin : g_rom
    localparam logic [LinW-1:0] Entry = LinW'(ccr_lin_entry(g, F));
    assign lin_rom[g] = Entry;
  end

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic div_ready;

  logic [LinW-1:0] lin_q [6];
  logic [PrW-1:0]  prod_q [6];
  logic [LumW-1:0] l1_q, l2_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [LumW-1:0] l1_4_q, l2_4_q;

  logic [SumW-1:0] sum1, sum2;
  logic [LumW-1:0] lmax, lmin;
  logic [SideW-1:0] side_out;

  // bubble-collapsing stage enables
  assign en4 = !v4_q || div_ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: channel linearization
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      lin_q[0] <= lin_rom[first_red_i];
      lin_q[1] <= lin_rom[first_green_i];
      lin_q[2] <= lin_rom[first_blue_i];
      lin_q[3] <= lin_rom[second_red_i];
      lin_q[4] <= lin_rom[second_green_i];
      lin_q[5] <= lin_rom[second_blue_i];
    end
  end

  // stage 2: weight multiplies
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod_q[0] <= PrW'(lin_q[0]) * PrW'(W_R);
      prod_q[1] <= PrW'(lin_q[1]) * PrW'(W_G);
      prod_q[2] <= PrW'(lin_q[2]) * PrW'(W_B);
      prod_q[3] <= PrW'(lin_q[3]) * PrW'(W_R);
      prod_q[4] <= PrW'(lin_q[4]) * PrW'(W_G);
      prod_q[5] <= PrW'(lin_q[5]) * PrW'(W_B);
    end
  end

  // stage 3: weighted sum, rounded
  assign sum1 = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + HALF;
  assign sum2 = SumW'(prod_q[3]) + SumW'(prod_q[4]) + SumW'(prod_q[5]) + HALF;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      l1_q <= sum1[F +: LumW];
      l2_q <= sum2[F +: LumW];
    end
  end

  // stage 4: order the luminances and add the flare offset
  assign lmax = (l1_q > l2_q) ? l1_q : l2_q;
  assign lmin = (l1_q > l2_q) ? l2_q : l1_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      num_q  <= NumW'(DenW'(lmax) + OFF) << R;
      den_q  <= DenW'(lmin) + OFF;
      l1_4_q <= l1_q;
      l2_4_q <= l2_q;
    end
  end

  ccr_div #(
    .NumW  (NumW),
    .DenW  (DenW),
    .QuoW  (QuoW),
    .SideW (SideW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_ready_o  (div_ready),
    .num_i       (num_q),
    .den_i       (den_q),
    .side_i      ({l1_4_q, l2_4_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quo_o       (ratio_q8_o),
    .side_o      (side_out)
  );

  assign first_luminance_o  = side_out[SideW-1 -: LumW];
  assign second_luminance_o = side_out[LumW-1:0];

  // ratio never below one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ratio_q8_o >= ONE_R))
    else $error("ratio below one");

  // equal luminances give exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (first_luminance_o == second_luminance_o)) |-> (ratio_q8_o == ONE_R))
    else $error("equal luminances not ratio one");

  // luminance never above full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((first_luminance_o <= (LumW'(1) << F)) &&
                     (second_luminance_o <= (LumW'(1) << F))))
    else $error("luminance above full scale");

endmodule

`default_nettype wire

/* sim/color_contrast_ratio_core_tb.sv */
// ----------------------------------------------------------------------------
// color_contrast_ratio_core_tb: self-checking bench for the contrast ratio core
//
// Drives color pairs over the valid/ready input channel and predicts each
// ratio and both luminances from an exactly computed sRGB channel table.
// Results are checked in order against the scoreboard under varied idling.
// ----------------------------------------------------------------------------
`default_nettype none

module color_contrast_ratio_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LumBits   = 16;
  localparam int unsigned RatioBits = 8;
  localparam int unsigned ChanW     = ccr_pkg::ChanW;
  localparam int unsigned Latency   = 4 + RatioBits + 5;
  localparam int unsigned NumRandom = 1230;

  typedef struct {
    logic [RatioBits+4:0] ratio;
    logic [LumBits:0]     lum_a;
    logic [LumBits:0]     lum_b;
  } contrast_t;

  // Scoreboard: predicts each accepted word and checks results in order
  class contrast_board;
    longint    lin_tbl[256];
    contrast_t pending[$];
    int        errors;
    int        checked;

    function new();
      bit [319:0] rhs;
      bit [319:0] lhs;
      bit [319:0] base;
      longint     lo;
      longint     hi;
      longint     mid;
      errors  = 0;
      checked = 0;
      base = 320'd1;
      repeat (12) base = base * 320'd10761;
      for (int v = 0; v < 256; v++) begin
        if (longint'(v) * 100000 <= 1001640) begin
          lin_tbl[v] = ((longint'(v) << (LumBits + 1)) * 10 + 32946) / 65892;
        end else begin
          // largest y with (2y-1)^5 * 10761^12 <= (40v+561)^12 * 2^(5*17)
          rhs = 320'd1;
          repeat (12) rhs = rhs * 320'(40 * v + 561);
          rhs = rhs << (5 * (LumBits + 1));
          lo = 0;
          hi = longint'(1) << LumBits;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = base;
            repeat (5) lhs = lhs * 320'(2 * mid - 1);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
          end
          lin_tbl[v] = lo;
        end
      end
    endfunction

    function longint luma(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b);
      longint acc;
      acc = 64'd13933 * lin_tbl[r] + 64'd46871 * lin_tbl[g] + 64'd4732 * lin_tbl[b]
          + (longint'(1) << (LumBits - 1));
      return acc >> LumBits;
    endfunction

    function void note_pair(logic [ChanW-1:0] r1, logic [ChanW-1:0] g1, logic [ChanW-1:0] b1,
                            logic [ChanW-1:0] r2, logic [ChanW-1:0] g2, logic [ChanW-1:0] b2);
      contrast_t e;
      longint la;
      longint lb;
      longint hi_l;
      longint lo_l;
      la   = luma(r1, g1, b1);
      lb   = luma(r2, g2, b2);
      hi_l = (la > lb) ? la : lb;
      lo_l = (la > lb) ? lb : la;
      e.ratio = (RatioBits + 5)'(((hi_l + 3277) << RatioBits) / (lo_l + 3277));
      e.lum_a = (LumBits + 1)'(la);
      e.lum_b = (LumBits + 1)'(lb);
      pending.push_back(e);
    endfunction

    function void check_result(logic [RatioBits+4:0] ratio, logic [LumBits:0] la,
                               logic [LumBits:0] lb);
      contrast_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: ratio %0d", ratio);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ratio !== e.ratio) begin
        $error("ratio_q8: expected %0d, actual %0d", e.ratio, ratio);
        errors++;
      end
      if (la !== e.lum_a) begin
        $error("first_luminance: expected %0d, actual %0d", e.lum_a, la);
        errors++;
      end
      if (lb !== e.lum_b) begin
        $error("second_luminance: expected %0d, actual %0d", e.lum_b, lb);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ChanW-1:0] first_red_i = '0;
  logic [ChanW-1:0] first_green_i = '0;
  logic [ChanW-1:0] first_blue_i = '0;
  logic [ChanW-1:0] second_red_i = '0;
  logic [ChanW-1:0] second_green_i = '0;
  logic [ChanW-1:0] second_blue_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RatioBits+4:0] ratio_q8_o;
  logic [LumBits:0] first_luminance_o;
  logic [LumBits:0] second_luminance_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent = 0;
  contrast_board board;

  color_contrast_ratio_core #(
    .LUM_FRAC_BITS  (LumBits),
    .RATIO_FRAC_BITS(RatioBits)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .first_red_i       (first_red_i),
    .first_green_i     (first_green_i),
    .first_blue_i      (first_blue_i),
    .second_red_i      (second_red_i),
    .second_green_i    (second_green_i),
    .second_blue_i     (second_blue_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ratio_q8_o        (ratio_q8_o),
    .first_luminance_o (first_luminance_o),
    .second_luminance_o(second_luminance_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: ready changes at the falling edge, results sampled at rising
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(ratio_q8_o, first_luminance_o, second_luminance_o);
    end
  end

  // Send one color pair; returns after the word is accepted
  task automatic send_pair(logic [ChanW-1:0] r1, logic [ChanW-1:0] g1, logic [ChanW-1:0] b1,
                           logic [ChanW-1:0] r2, logic [ChanW-1:0] g2, logic [ChanW-1:0] b2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    first_red_i    = r1;
    first_green_i  = g1;
    first_blue_i   = b1;
    second_red_i   = r2;
    second_green_i = g2;
    second_blue_i  = b2;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    board.note_pair(r1, g1, b1, r2, g2, b2);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Random pair: mostly independent colors, some equal or near-equal, some near black
  task automatic send_random();
    logic [ChanW-1:0] c[6];
    int unsigned kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 6; i++) c[i] = ChanW'($urandom);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) c[i + 3] = c[i] ^ ChanW'($urandom_range(3));
    end else if (kind == 1) begin
      for (int i = 0; i < 6; i++) c[i] = ChanW'($urandom_range(14));
    end else if (kind == 2) begin
      for (int i = 0; i < 3; i++) c[i + 3] = c[i];
    end
    send_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
  endtask

  initial begin
    #2_000_000;
    $display("color_contrast_ratio_core: mismatch");
    $finish;
  end

  initial begin
    int waited;
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, equal colors, single channels, linear/power boundary
    send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
    send_pair(8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11);
    send_pair(8'd11, 8'd10, 8'd11, 8'd10, 8'd11, 8'd10);
    send_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
    send_pair(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    send_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pair(8'd254, 8'd254, 8'd254, 8'd1, 8'd1, 8'd1);
    send_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pair(8'd119, 8'd119, 8'd119, 8'd255, 8'd255, 8'd255);

    // Random: three idling regimes
    send_idle_pct = 17;
    recv_idle_pct = 72;
    repeat (NumRandom / 3) send_random();
    send_idle_pct = 72;
    recv_idle_pct = 17;
    repeat (NumRandom / 3) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (NumRandom - 2 * (NumRandom / 3)) send_random();

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (2 * Latency + 10) @(negedge clk_i);

    $display("sent %0d color pairs, checked %0d results across three idling regimes",
             words_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("color_contrast_ratio_core: match");
    end else begin
      $display("color_contrast_ratio_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
